/* rtl/skf_pkg.sv */
// shared types, constants and the step table of the scalar kalman filter
`timescale 1ns / 1ps
package skf_pkg;

   // word format: signed fixed point, FB fractional bits
   localparam int DW   = 32;
   localparam int FB   = 24;
   localparam int UW   = DW - 1;
   localparam int PW   = 2 * DW;
   localparam int CW   = $clog2(DW);
   localparam int IW   = 3;
   localparam int SW   = 5;

   typedef logic signed [DW-1:0] word_type;
   typedef logic [DW-1:0]        mag_type;
   typedef logic [UW-1:0]        uword_type;
   typedef logic [IW-1:0]        csr_addr_type;
   typedef logic [SW-1:0]        step_type;

   localparam word_type WMAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);

   // reset values of the registers, rounded to nearest
   localparam longint unsigned ONE = 64'd1 << FB;
   localparam word_type  RST_STATE_OFFSET = DW'((ONE + 64'd5000) / 64'd10000);
   localparam uword_type RST_PROCESS_NOISE = UW'((ONE + 64'd10) / 64'd20);
   localparam word_type  RST_TRANSITION_GAIN = DW'((ONE + 64'd10) / 64'd20);
   localparam uword_type RST_MEASUREMENT_NOISE = UW'((ONE + 64'd50) / 64'd100);
   localparam word_type  RST_OBSERVATION_GAIN = DW'((64'd19 * ONE + 64'd10) / 64'd20);
   localparam word_type  RST_OBSERVATION_OFFSET = DW'((ONE + 64'd5000) / 64'd10000);

   typedef enum logic [IW-1:0] {
      CSR_STATE_OFFSET       = 3'd0,
      CSR_PROCESS_NOISE      = 3'd1,
      CSR_TRANSITION_GAIN    = 3'd2,
      CSR_MEASUREMENT_NOISE  = 3'd3,
      CSR_OBSERVATION_GAIN   = 3'd4,
      CSR_OBSERVATION_OFFSET = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [4:0] {
      OPD_A,
      OPD_P,
      OPD_AP,
      OPD_PP,
      OPD_F,
      OPD_K,
      OPD_KZ,
      OPD_T,
      OPD_V,
      OPD_FIT,
      OPD_RES,
      OPD_Y,
      OPD_C,
      OPD_Q,
      OPD_TG,
      OPD_H,
      OPD_Z,
      OPD_D
   } opd_type;

   typedef struct packed {
      op_type  op;
      opd_type srca;
      opd_type srcb;
      opd_type dst;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MRND,
      ST_DIV,
      ST_DRND,
      ST_DONE
   } state_type;

   localparam int NSTEP = 21;
   localparam step_type LAST_STEP = SW'(NSTEP - 1);

   // one operation per step, in the order of the filter equations
   function automatic uop_type uop_at(input step_type idx);
      uop_type u;
      case (idx)
         5'd0:    u = '{OP_MUL, OPD_TG, OPD_A,   OPD_T};
         5'd1:    u = '{OP_ADD, OPD_T,  OPD_C,   OPD_AP};
         5'd2:    u = '{OP_MUL, OPD_TG, OPD_P,   OPD_T};
         5'd3:    u = '{OP_MUL, OPD_T,  OPD_TG,  OPD_T};
         5'd4:    u = '{OP_ADD, OPD_T,  OPD_Q,   OPD_PP};
         5'd5:    u = '{OP_MUL, OPD_Z,  OPD_PP,  OPD_T};
         5'd6:    u = '{OP_MUL, OPD_T,  OPD_Z,   OPD_T};
         5'd7:    u = '{OP_ADD, OPD_T,  OPD_H,   OPD_F};
         5'd8:    u = '{OP_MUL, OPD_PP, OPD_Z,   OPD_T};
         5'd9:    u = '{OP_DIV, OPD_T,  OPD_F,   OPD_K};
         5'd10:   u = '{OP_MUL, OPD_K,  OPD_Z,   OPD_KZ};
         5'd11:   u = '{OP_MUL, OPD_Z,  OPD_AP,  OPD_T};
         5'd12:   u = '{OP_SUB, OPD_Y,  OPD_T,   OPD_V};
         5'd13:   u = '{OP_SUB, OPD_V,  OPD_D,   OPD_V};
         5'd14:   u = '{OP_MUL, OPD_KZ, OPD_V,   OPD_T};
         5'd15:   u = '{OP_ADD, OPD_AP, OPD_T,   OPD_A};
         5'd16:   u = '{OP_MUL, OPD_KZ, OPD_PP,  OPD_T};
         5'd17:   u = '{OP_SUB, OPD_PP, OPD_T,   OPD_P};
         5'd18:   u = '{OP_MUL, OPD_Z,  OPD_A,   OPD_T};
         5'd19:   u = '{OP_ADD, OPD_T,  OPD_D,   OPD_FIT};
         5'd20:   u = '{OP_SUB, OPD_Y,  OPD_FIT, OPD_RES};
         default: u = '{OP_ADD, OPD_T,  OPD_T,   OPD_T};
      endcase
      return u;
   endfunction

endpackage

/* rtl/skf_if.sv */
// channel interfaces of the scalar kalman filter: input, result and register write
`timescale 1ns / 1ps
interface skf_req_if;
   import skf_pkg::*;
   logic     valid;
   logic     ready;
   word_type sample;
   logic     series_start;

   modport source (output valid, output sample, output series_start, input ready);
   modport sink (input valid, input sample, input series_start, output ready);
endinterface

interface skf_rsp_if;
   import skf_pkg::*;
   logic     valid;
   logic     ready;
   word_type observed;
   word_type fitted;
   word_type residual;
   logic     saturated;

   modport source (output valid, output observed, output fitted, output residual,
                   output saturated, input ready);
   modport sink (input valid, input observed, input fitted, input residual,
                 input saturated, output ready);
endinterface

interface skf_csr_if;
   import skf_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type index;
   word_type     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/scalar_kalman_filter.sv */
// scalar kalman filter top level: sequencer around one shared multiply/add/divide unit
// Usage:
//   req_chan carries one observation (sample, series_start) per item; series_start
//   reseeds the filter from that sample with the prior variance taken as Q.
//   rsp_chan returns one item per input: the sample, the fitted value Z*a+d, the
//   residual and a flag set when any intermediate value clipped.
//   csr_chan writes registers 0..5 (c, Q, T, H, Z, d); it is always ready and
//   should only be written while no item is in flight. Other indexes are ignored.
// Timing:
//   a small sequencer walks 21 steps through one shared unit: add/sub write back
//   from the execute state, a multiply goes through a product register, then
//   round and clip, and the gain divide runs one quotient bit a cycle, then
//   rounds, or skips that loop when F is zero or the quotient clips. req ready
//   rises in the same cycle as the result is loaded into the output register.
//   req ready is high only while the sequencer is idle.
// Reset: registers take their default values, filtered state and variance clear.
// Stall: the result sits in an output register; the sequencer accepts the next
//   item meanwhile and holds its own result until that register frees up.
`timescale 1ns / 1ps
module scalar_kalman_filter (
   input logic       clock,
   input logic       reset,
   skf_req_if.sink   req_chan,
   skf_rsp_if.source rsp_chan,
   skf_csr_if.sink   csr_chan
);
   import skf_pkg::*;

   // configuration
   word_type  c_ff, c_in;
   uword_type q_ff, q_in;
   word_type  tg_ff, tg_in;
   uword_type h_ff, h_in;
   word_type  z_ff, z_in;
   word_type  d_ff, d_in;

   // filter state and working registers
   word_type a_ff, a_in;
   word_type p_ff, p_in;
   word_type ap_ff, ap_in;
   word_type pp_ff, pp_in;
   word_type f_ff, f_in;
   word_type k_ff, k_in;
   word_type kz_ff, kz_in;
   word_type t_ff, t_in;
   word_type v_ff, v_in;
   word_type fit_ff, fit_in;
   word_type res_ff, res_in;
   word_type y_ff, y_in;
   logic     clip_ff, clip_in;

   // sequencer
   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   // shared unit
   logic [PW-1:0] prod_ff, prod_in;
   logic          neg_ff, neg_in;
   mag_type       rem_ff, rem_in;
   mag_type       dlo_ff, dlo_in;
   mag_type       quo_ff, quo_in;
   mag_type       dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type obs_out_ff, obs_out_in;
   word_type fit_out_ff, fit_out_in;
   word_type res_out_ff, res_out_in;
   logic     sat_out_ff, sat_out_in;

   // combinational
   uop_type       uop;
   word_type      opa, opb;
   mag_type       mag_a, mag_b;
   logic          sign_x;
   logic [PW-1:0] prod_raw;
   logic [DW:0]   sum_w;
   logic          add_clip;
   word_type      add_res;
   logic [PW-1:0] mul_rnd;
   logic [DW:0]   mul_sat;
   logic          div_zero;
   logic          div_over;
   logic [DW:0]   div_sat;
   logic [DW:0]   rem_sh;
   logic          rem_ge;
   logic          rnd_up;
   logic [DW:0]   q_plus;
   logic          q_over;
   logic [DW:0]   div_fin;
   logic          wr_en;
   word_type      wr_val;
   logic          wr_clip;
   logic          req_fire;
   logic          out_load;
   state_type     adv_state;

   // apply sign to a magnitude, clip to the word range; msb of result is the clip flag
   function automatic logic [DW:0] sign_sat(input logic [PW-1:0] m, input logic neg,
                                            input logic over);
      logic [PW-1:0] lim;
      logic [PW-1:0] v;
      logic          clip;
      lim  = neg ? (PW'(1) << (DW - 1)) : ((PW'(1) << (DW - 1)) - PW'(1));
      clip = over || (m > lim);
      v    = clip ? lim : m;
      if (neg) begin
         v = ~v + PW'(1);
      end
      return {clip, v[DW-1:0]};
   endfunction

   assign req_fire = req_chan.valid && (state_ff == ST_IDLE);
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign adv_state = (step_ff == LAST_STEP) ? ST_DONE : ST_EXEC;

   // operand selection and shared arithmetic
   always_comb begin
      uop = uop_at(step_ff);
      case (uop.srca)
         OPD_A:   opa = a_ff;
         OPD_P:   opa = p_ff;
         OPD_AP:  opa = ap_ff;
         OPD_PP:  opa = pp_ff;
         OPD_F:   opa = f_ff;
         OPD_K:   opa = k_ff;
         OPD_KZ:  opa = kz_ff;
         OPD_T:   opa = t_ff;
         OPD_V:   opa = v_ff;
         OPD_FIT: opa = fit_ff;
         OPD_Y:   opa = y_ff;
         OPD_C:   opa = c_ff;
         OPD_Q:   opa = word_type'({1'b0, q_ff});
         OPD_TG:  opa = tg_ff;
         OPD_H:   opa = word_type'({1'b0, h_ff});
         OPD_Z:   opa = z_ff;
         OPD_D:   opa = d_ff;
         default: opa = '0;
      endcase
      case (uop.srcb)
         OPD_A:   opb = a_ff;
         OPD_P:   opb = p_ff;
         OPD_AP:  opb = ap_ff;
         OPD_PP:  opb = pp_ff;
         OPD_F:   opb = f_ff;
         OPD_K:   opb = k_ff;
         OPD_KZ:  opb = kz_ff;
         OPD_T:   opb = t_ff;
         OPD_V:   opb = v_ff;
         OPD_FIT: opb = fit_ff;
         OPD_Y:   opb = y_ff;
         OPD_C:   opb = c_ff;
         OPD_Q:   opb = word_type'({1'b0, q_ff});
         OPD_TG:  opb = tg_ff;
         OPD_H:   opb = word_type'({1'b0, h_ff});
         OPD_Z:   opb = z_ff;
         OPD_D:   opb = d_ff;
         default: opb = '0;
      endcase

      mag_a    = opa[DW-1] ? (~mag_type'(opa) + mag_type'(1)) : mag_type'(opa);
      mag_b    = opb[DW-1] ? (~mag_type'(opb) + mag_type'(1)) : mag_type'(opb);
      sign_x   = opa[DW-1] ^ opb[DW-1];
      prod_raw = PW'(mag_a) * PW'(mag_b);

      if (uop.op == OP_SUB) begin
         sum_w = {opa[DW-1], opa} - {opb[DW-1], opb};
      end else begin
         sum_w = {opa[DW-1], opa} + {opb[DW-1], opb};
      end
      add_clip = sum_w[DW] ^ sum_w[DW-1];
      add_res  = add_clip ? (sum_w[DW] ? WMIN : WMAX) : word_type'(sum_w[DW-1:0]);

      mul_rnd = prod_ff + HALF;
      mul_sat = sign_sat(mul_rnd >> FB, neg_ff, 1'b0);

      // quotient of 2^DW or more is known to clip before dividing
      div_zero = (opb == '0);
      div_over = PW'(mag_a) >= (PW'(mag_b) << (DW - FB));
      div_sat  = sign_sat('0, sign_x, 1'b1);

      rem_sh  = {rem_ff, dlo_ff[DW-1]};
      rem_ge  = rem_sh >= {1'b0, dvs_ff};
      rnd_up  = {rem_ff, 1'b0} >= {1'b0, dvs_ff};
      q_plus  = {1'b0, quo_ff} + (DW+1)'(rnd_up);
      q_over  = quo_ff > (mag_type'(1) << (DW - 1));
      div_fin = sign_sat(PW'(q_plus), neg_ff, q_over);
   end

   // result write-back selection
   always_comb begin
      wr_en   = 1'b0;
      wr_val  = add_res;
      wr_clip = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            case (uop.op)
               OP_ADD, OP_SUB: begin
                  wr_en   = 1'b1;
                  wr_val  = add_res;
                  wr_clip = add_clip;
               end
               OP_DIV: begin
                  if (div_zero) begin
                     wr_en  = 1'b1;
                     wr_val = '0;
                  end else if (div_over) begin
                     wr_en   = 1'b1;
                     wr_val  = word_type'(div_sat[DW-1:0]);
                     wr_clip = div_sat[DW];
                  end
               end
               default: ;
            endcase
         end
         ST_MRND: begin
            wr_en   = 1'b1;
            wr_val  = word_type'(mul_sat[DW-1:0]);
            wr_clip = mul_sat[DW];
         end
         ST_DRND: begin
            wr_en   = 1'b1;
            wr_val  = word_type'(div_fin[DW-1:0]);
            wr_clip = div_fin[DW];
         end
         default: ;
      endcase
   end

   // next values of the datapath registers
   always_comb begin
      c_in   = c_ff;
      q_in   = q_ff;
      tg_in  = tg_ff;
      h_in   = h_ff;
      z_in   = z_ff;
      d_in   = d_ff;
      a_in   = a_ff;
      p_in   = p_ff;
      ap_in  = ap_ff;
      pp_in  = pp_ff;
      f_in   = f_ff;
      k_in   = k_ff;
      kz_in  = kz_ff;
      t_in   = t_ff;
      v_in   = v_ff;
      fit_in = fit_ff;
      res_in = res_ff;
      y_in   = y_ff;
      clip_in = clip_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      dlo_in  = dlo_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      obs_out_in   = obs_out_ff;
      fit_out_in   = fit_out_ff;
      res_out_in   = res_out_ff;
      sat_out_in   = sat_out_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_STATE_OFFSET:       c_in  = csr_chan.wdata;
            CSR_PROCESS_NOISE:      q_in  = uword_type'(csr_chan.wdata[UW-1:0]);
            CSR_TRANSITION_GAIN:    tg_in = csr_chan.wdata;
            CSR_MEASUREMENT_NOISE:  h_in  = uword_type'(csr_chan.wdata[UW-1:0]);
            CSR_OBSERVATION_GAIN:   z_in  = csr_chan.wdata;
            CSR_OBSERVATION_OFFSET: d_in  = csr_chan.wdata;
            default: ;
         endcase
      end

      if (req_fire) begin
         y_in    = req_chan.sample;
         clip_in = 1'b0;
         step_in = '0;
         // a new series starts from the sample itself with prior variance Q
         if (req_chan.series_start) begin
            a_in = req_chan.sample;
            p_in = word_type'({1'b0, q_ff});
         end
      end

      if (state_ff == ST_EXEC) begin
         if (uop.op == OP_MUL) begin
            prod_in = prod_raw;
            neg_in  = sign_x;
         end
         if (uop.op == OP_DIV) begin
            neg_in = sign_x;
            dvs_in = mag_b;
            rem_in = mag_a >> (DW - FB);
            dlo_in = mag_a << FB;
            quo_in = '0;
            cnt_in = CW'(DW - 1);
         end
      end

      if (state_ff == ST_DIV) begin
         rem_in = rem_ge ? mag_type'(rem_sh - {1'b0, dvs_ff}) : mag_type'(rem_sh[DW-1:0]);
         quo_in = {quo_ff[DW-2:0], rem_ge};
         dlo_in = dlo_ff << 1;
         cnt_in = cnt_ff - CW'(1);
      end

      if (wr_en) begin
         clip_in = clip_ff | wr_clip;
         step_in = step_ff + SW'(1);
         case (uop.dst)
            OPD_A:   a_in   = wr_val;
            OPD_P:   p_in   = wr_val;
            OPD_AP:  ap_in  = wr_val;
            OPD_PP:  pp_in  = wr_val;
            OPD_F:   f_in   = wr_val;
            OPD_K:   k_in   = wr_val;
            OPD_KZ:  kz_in  = wr_val;
            OPD_T:   t_in   = wr_val;
            OPD_V:   v_in   = wr_val;
            OPD_FIT: fit_in = wr_val;
            OPD_RES: res_in = wr_val;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         obs_out_in   = y_ff;
         fit_out_in   = fit_ff;
         res_out_in   = res_ff;
         sat_out_in   = clip_ff;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (uop.op)
               OP_MUL:  state_in = ST_MRND;
               OP_DIV:  state_in = (div_zero || div_over) ? adv_state : ST_DIV;
               default: state_in = adv_state;
            endcase
         end
         ST_MRND: state_in = adv_state;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DRND;
            end
         end
         ST_DRND: state_in = adv_state;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // channel outputs
   always_comb begin
      req_chan.ready     = (state_ff == ST_IDLE);
      csr_chan.ready     = 1'b1;
      rsp_chan.valid     = rsp_valid_ff;
      rsp_chan.observed  = obs_out_ff;
      rsp_chan.fitted    = fit_out_ff;
      rsp_chan.residual  = res_out_ff;
      rsp_chan.saturated = sat_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         c_ff         <= RST_STATE_OFFSET;
         q_ff         <= RST_PROCESS_NOISE;
         tg_ff        <= RST_TRANSITION_GAIN;
         h_ff         <= RST_MEASUREMENT_NOISE;
         z_ff         <= RST_OBSERVATION_GAIN;
         d_ff         <= RST_OBSERVATION_OFFSET;
         a_ff         <= '0;
         p_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c_ff         <= c_in;
         q_ff         <= q_in;
         tg_ff        <= tg_in;
         h_ff         <= h_in;
         z_ff         <= z_in;
         d_ff         <= d_in;
         a_ff         <= a_in;
         p_ff         <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      ap_ff      <= ap_in;
      pp_ff      <= pp_in;
      f_ff       <= f_in;
      k_ff       <= k_in;
      kz_ff      <= kz_in;
      t_ff       <= t_in;
      v_ff       <= v_in;
      fit_ff     <= fit_in;
      res_ff     <= res_in;
      y_ff       <= y_in;
      clip_ff    <= clip_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      dlo_ff     <= dlo_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      obs_out_ff <= obs_out_in;
      fit_out_ff <= fit_out_in;
      res_out_ff <= res_out_in;
      sat_out_ff <= sat_out_in;
   end

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the scalar kalman filter: fixed-point predictor and scoreboard
`timescale 1ns / 1ps
import skf_pkg::*;

typedef longint          s64_type;
typedef longint unsigned u64_type;

typedef struct packed {
   word_type observed;
   word_type fitted;
   word_type residual;
   logic     saturated;
} kalman_result_type;

class kalman_scoreboard;
   s64_type c_off, q_var, t_gain, h_var, z_gain, d_off;
   s64_type level, level_var;
   bit clipped;
   kalman_result_type pending[$];
   int mismatches;
   int checked;
   int sat_seen;

   function new();
      c_off     = s64_type'(RST_STATE_OFFSET);
      q_var     = s64_type'(RST_PROCESS_NOISE);
      t_gain    = s64_type'(RST_TRANSITION_GAIN);
      h_var     = s64_type'(RST_MEASUREMENT_NOISE);
      z_gain    = s64_type'(RST_OBSERVATION_GAIN);
      d_off     = s64_type'(RST_OBSERVATION_OFFSET);
      level     = 0;
      level_var = 0;
   endfunction

   function void write_reg(csr_addr_type idx, word_type wdata);
      case (idx)
         CSR_STATE_OFFSET:       c_off  = s64_type'(wdata);
         CSR_PROCESS_NOISE:      q_var  = s64_type'(wdata[UW-1:0]);
         CSR_TRANSITION_GAIN:    t_gain = s64_type'(wdata);
         CSR_MEASUREMENT_NOISE:  h_var  = s64_type'(wdata[UW-1:0]);
         CSR_OBSERVATION_GAIN:   z_gain = s64_type'(wdata);
         CSR_OBSERVATION_OFFSET: d_off  = s64_type'(wdata);
         default: ;
      endcase
   endfunction

   function s64_type clip_word(s64_type v);
      if (v > s64_type'(WMAX)) begin
         clipped = 1'b1;
         return s64_type'(WMAX);
      end
      if (v < s64_type'(WMIN)) begin
         clipped = 1'b1;
         return s64_type'(WMIN);
      end
      return v;
   endfunction

   function u64_type magnitude(s64_type v);
      return (v < 0) ? u64_type'(-v) : u64_type'(v);
   endfunction

   function s64_type signed_limit(u64_type m, bit neg, bit over);
      u64_type lim;
      lim = neg ? (u64_type'(1) << (DW - 1)) : (u64_type'(1) << (DW - 1)) - 1;
      if (over || m > lim) begin
         clipped = 1'b1;
         m = lim;
      end
      return neg ? -s64_type'(m) : s64_type'(m);
   endfunction

   function s64_type qadd(s64_type a, s64_type b);
      return clip_word(a + b);
   endfunction

   function s64_type qsub(s64_type a, s64_type b);
      return clip_word(a - b);
   endfunction

   // operands are always within the word range, so the product fits in 64 bits
   function s64_type qmul(s64_type a, s64_type b);
      u64_type prod;
      prod = magnitude(a) * magnitude(b) + (u64_type'(1) << (FB - 1));
      return signed_limit(prod >> FB, (a < 0) != (b < 0), 1'b0);
   endfunction

   function s64_type qdiv(s64_type n, s64_type d);
      u64_type num, den, quo, rem;
      bit neg;
      num = magnitude(n) << FB;
      den = magnitude(d);
      quo = num / den;
      rem = num % den;
      neg = (n < 0) != (d < 0);
      if (quo > (u64_type'(1) << (DW - 1)))
         return signed_limit(0, neg, 1'b1);
      if (2 * rem >= den)
         quo++;
      return signed_limit(quo, neg, 1'b0);
   endfunction

   function void note_sample(word_type sample, logic series_start);
      s64_type y, a0, p0, ap, pp, f, k, kz, v, fit, res;
      kalman_result_type want;
      clipped = 1'b0;
      y = s64_type'(sample);
      if (series_start) begin
         a0 = y;
         p0 = q_var;
      end else begin
         a0 = level;
         p0 = level_var;
      end
      ap = qadd(qmul(t_gain, a0), c_off);
      pp = qadd(qmul(qmul(t_gain, p0), t_gain), q_var);
      f  = qadd(qmul(qmul(z_gain, pp), z_gain), h_var);
      // zero innovation variance gives zero gain, and the numerator is not formed
      if (f == 0)
         k = 0;
      else
         k = qdiv(qmul(pp, z_gain), f);
      kz = qmul(k, z_gain);
      v  = qsub(qsub(y, qmul(z_gain, ap)), d_off);
      level     = qadd(ap, qmul(kz, v));
      level_var = qsub(pp, qmul(kz, pp));
      fit = qadd(qmul(z_gain, level), d_off);
      res = qsub(y, fit);
      want.observed  = word_type'(y);
      want.fitted    = word_type'(fit);
      want.residual  = word_type'(res);
      want.saturated = clipped;
      if (clipped)
         sat_seen++;
      pending.push_back(want);
   endfunction

   function void check_result(kalman_result_type got);
      kalman_result_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result with no item pending: obs %h fit %h res %h sat %b",
                     got.observed, got.fitted, got.residual, got.saturated);
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on result %0d: expected obs %h fit %h res %h sat %b",
                     checked, want.observed, want.fitted, want.residual, want.saturated);
            $display("                         actual   obs %h fit %h res %h sat %b",
                     got.observed, got.fitted, got.residual, got.saturated);
         end
      end
   endfunction
endclass

module tb_top;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RX_HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 100;
   localparam int RAND_PHASES     = 10;
   localparam int PHASE_ITEMS     = 153;
   localparam int PRESSURE_PHASE  = 3;

   localparam csr_addr_type CSR_UNUSED_LO = 3'd6;
   localparam csr_addr_type CSR_UNUSED_HI = 3'd7;

   localparam word_type FX_ONE     = word_type'(32'h0100_0000);
   localparam word_type FX_HALF    = word_type'(32'h0080_0000);
   localparam word_type FX_SIXTEEN = word_type'(32'h1000_0000);
   localparam word_type UMAX       = word_type'(32'h7FFF_FFFF);

   logic clock = 1'b0;
   logic reset;

   skf_req_if req_bus ();
   skf_rsp_if rsp_bus ();
   skf_csr_if csr_bus ();

   scalar_kalman_filter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   kalman_scoreboard sb;
   int  items_sent;
   int  config_sets;
   int  stall_cycles;
   int  rx_pick;
   bit  rx_hold_req;
   bit  steady_sender;

   always #5 clock = ~clock;

   // monitor: values seen here are those present just before the edge
   always @(posedge clock) begin
      kalman_result_type got;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.write_reg(csr_bus.index, csr_bus.wdata);
         if (req_bus.valid && req_bus.ready)
            sb.note_sample(req_bus.sample, req_bus.series_start);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.observed  = rsp_bus.observed;
            got.fitted    = rsp_bus.fitted;
            got.residual  = rsp_bus.residual;
            got.saturated = rsp_bus.saturated;
            sb.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", stall_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 10) begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(50, 200)) @(posedge clock);
            end else if (rx_pick < 65) begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end else if (rx_pick < 95) begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(1, 5)) @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(20, 150)) @(posedge clock);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_sender || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 5);
      if (r < 95)
         return $urandom_range(6, 40);
      return $urandom_range(41, 150);
   endfunction

   function automatic word_type rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return word_type'($urandom_range(0, 32'h0800_0000)) - word_type'(32'h0400_0000);
      if (r < 80)
         return word_type'($urandom);
      if (r < 90)
         return word_type'($urandom_range(0, 512)) - word_type'(256);
      case ($urandom_range(0, 4))
         0:       return WMAX;
         1:       return WMIN;
         2:       return word_type'(1);
         3:       return word_type'(-1);
         default: return '0;
      endcase
   endfunction

   function automatic word_type rand_reg(input csr_index_type which);
      int r;
      bit variance;
      r = $urandom_range(0, 99);
      variance = (which == CSR_PROCESS_NOISE) || (which == CSR_MEASUREMENT_NOISE);
      if (r < 15)
         return word_type'($urandom);
      if (r < 25) begin
         if (variance)
            return $urandom_range(0, 1) ? UMAX : '0;
         return $urandom_range(0, 1) ? WMAX : WMIN;
      end
      case (which)
         CSR_PROCESS_NOISE, CSR_MEASUREMENT_NOISE:
            return word_type'($urandom_range(0, 32'h0080_0000));
         CSR_TRANSITION_GAIN:
            return word_type'($urandom_range(0, 32'h0300_0000)) - word_type'(32'h0180_0000);
         CSR_OBSERVATION_GAIN:
            return word_type'($urandom_range(0, 32'h0400_0000)) - word_type'(32'h0200_0000);
         default:
            return word_type'($urandom_range(0, 32'h0200_0000)) - word_type'(32'h0100_0000);
      endcase
   endfunction

   // valid stays up on return so a following item can go out back to back
   task automatic send_sample(input word_type sample, input logic series_start);
      req_bus.valid        <= 1'b1;
      req_bus.sample       <= sample;
      req_bus.series_start <= series_start;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_with_gap(input word_type sample, input logic series_start);
      send_sample(sample, series_start);
      sender_gap(pick_gap());
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.checked < items_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_addr_type idx, input word_type wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= wdata;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic csr_release();
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_all(input word_type c, input word_type q, input word_type t,
                              input word_type h, input word_type z, input word_type d);
      csr_write(CSR_STATE_OFFSET, c);
      csr_write(CSR_PROCESS_NOISE, q);
      csr_write(CSR_TRANSITION_GAIN, t);
      csr_write(CSR_MEASUREMENT_NOISE, h);
      csr_write(CSR_OBSERVATION_GAIN, z);
      csr_write(CSR_OBSERVATION_OFFSET, d);
      csr_release();
      config_sets++;
   endtask

   task automatic run_directed();
      // reset defaults; the first item continues from the cleared state
      send_with_gap('0, 1'b0);
      send_with_gap(FX_ONE, 1'b1);
      send_with_gap(FX_ONE, 1'b0);
      send_with_gap(WMAX, 1'b0);
      send_with_gap(WMIN, 1'b0);
      send_with_gap(WMAX, 1'b1);
      send_with_gap(WMIN, 1'b1);
      send_with_gap(word_type'(-1), 1'b0);
      send_with_gap(word_type'(1), 1'b0);
      send_with_gap('0, 1'b1);
      wait_drained();

      // zero observation gain and noise: innovation variance is zero
      program_all(FX_HALF, FX_ONE, FX_ONE, '0, '0, '0);
      // writes to unused indexes must leave every register alone
      csr_write(CSR_UNUSED_LO, WMAX);
      csr_write(CSR_UNUSED_HI, WMIN);
      csr_release();
      send_with_gap(FX_ONE, 1'b1);
      send_with_gap(WMIN, 1'b0);
      send_with_gap(-FX_ONE, 1'b0);
      wait_drained();

      program_all(WMAX, UMAX, WMAX, UMAX, WMAX, WMAX);
      send_with_gap(WMAX, 1'b1);
      send_with_gap(WMIN, 1'b0);
      send_with_gap('0, 1'b0);
      wait_drained();

      program_all(WMIN, '0, WMIN, '0, WMIN, WMIN);
      send_with_gap(WMIN, 1'b1);
      send_with_gap(WMAX, 1'b0);
      send_with_gap(FX_ONE, 1'b0);
      wait_drained();

      // large observation gain drives the gain past one and the variance negative;
      // the variance write also carries a set top bit that must be dropped
      program_all('0, word_type'(32'h8100_0000), FX_ONE, '0, FX_SIXTEEN, '0);
      send_with_gap(FX_ONE, 1'b1);
      send_with_gap(FX_HALF, 1'b0);
      send_with_gap(-FX_ONE, 1'b0);
      send_with_gap(FX_ONE, 1'b0);
      wait_drained();
   endtask

   task automatic run_random();
      logic start;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         program_all(rand_reg(CSR_STATE_OFFSET), rand_reg(CSR_PROCESS_NOISE),
                     rand_reg(CSR_TRANSITION_GAIN), rand_reg(CSR_MEASUREMENT_NOISE),
                     rand_reg(CSR_OBSERVATION_GAIN), rand_reg(CSR_OBSERVATION_OFFSET));
         if ($urandom_range(0, 3) == 0) begin
            csr_write($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                      word_type'($urandom));
            csr_release();
         end
         steady_sender = (ph % 3 == 0) || (ph == PRESSURE_PHASE);
         if (ph == PRESSURE_PHASE)
            rx_hold_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 0)
               start = $urandom_range(0, 1);
            else
               start = ($urandom_range(0, 15) == 0);
            send_with_gap(rand_sample(), start);
         end
         steady_sender = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      sb = new();
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.sample       <= '0;
      req_bus.series_start <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.wdata        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.pending.size() != 0)
         $display("%0d expected results never arrived", sb.pending.size());
      $display("covered %0d samples over %0d register settings, %0d results compared",
               items_sent, config_sets, sb.checked);
      $display("%0d results carried the clip flag, %0d mismatches", sb.sat_seen,
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/skf_pkg.sv
rtl/skf_if.sv
rtl/scalar_kalman_filter.sv
tb/tb_top.sv
